[hw/rtl/stable_max_priority_queue_assert.svh]
// Assertion macros shared by the priority queue RTL.
// Needs nothing else; used by stable_max_priority_queue.sv.
`ifndef STABLE_MAX_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_MAX_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, gated off during reset
`define SMPQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("smpq: check failed");

// Next-cycle implication, gated off during reset
`define SMPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("smpq: check failed");

`endif

[hw/rtl/smpq_pkg.sv]
// Package for the stable max priority queue: beat types, codes, defaults.
// No dependencies; used by smpq_cell and stable_max_priority_queue.
package smpq_pkg;

   localparam int DEF_CAPACITY     = 16;
   localparam int DEF_KEY_WIDTH    = 16;
   localparam int KEY_PORT_WIDTH   = 16;
   localparam int PAYLOAD_WIDTH    = 32;
   localparam int COUNT_PORT_WIDTH = 5;

   // Opcodes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_PEEK   = 2'd2;

   // Status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_NULL  = 2'd3;

   typedef struct packed {
      logic [1:0]                opcode;
      logic [KEY_PORT_WIDTH-1:0] key;
      logic [PAYLOAD_WIDTH-1:0]  payload;
   } req_type;

   typedef struct packed {
      logic [1:0]                  status;
      logic [KEY_PORT_WIDTH-1:0]   front_key;
      logic [PAYLOAD_WIDTH-1:0]    front_payload;
      logic [COUNT_PORT_WIDTH-1:0] count;
   } rsp_type;

   // Broadcast control to every cell of the row
   typedef struct packed {
      logic                     insert;
      logic                     remove;
      logic [PAYLOAD_WIDTH-1:0] payload;
   } cell_ctl_type;

endpackage

[hw/rtl/stable_max_priority_queue.sv]
// Stable max priority queue: a row of CAPACITY cells kept sorted by key, largest
// at the front, equal keys in arrival order. A command is taken whenever start is
// high; busy never rises, so one command can be issued every cycle. Every command
// gives exactly one result, on the rsp_ ports in the cycle after it is taken, marked
// by rsp_valid for that single cycle; the receiver must take it then. All cells
// compare against the new key in parallel and shift in the same clock. Depends on
// smpq_pkg, smpq_cell and the macros.
module stable_max_priority_queue #(
   parameter int CAPACITY  = smpq_pkg::DEF_CAPACITY,
   parameter int KEY_WIDTH = smpq_pkg::DEF_KEY_WIDTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  smpq_pkg::req_type req_item,
   output logic              rsp_valid,
   output smpq_pkg::rsp_type rsp_item
);
   import smpq_pkg::*;

   `include "stable_max_priority_queue_assert.svh"

   localparam int CW = $clog2(CAPACITY + 1);

   logic [CW-1:0]            count_ff, count_in;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_ff, rsp_in;
   logic                     accept;
   logic                     do_insert, do_remove;
   logic                     is_insert, is_full, is_empty, is_null;
   logic [KEY_WIDTH-1:0]     ins_key;
   cell_ctl_type             ctl;

   logic [KEY_WIDTH-1:0]     cell_key [CAPACITY];
   logic [PAYLOAD_WIDTH-1:0] cell_payload [CAPACITY];
   logic                     cell_ge [CAPACITY];

   // Never busy: a command is taken whenever start is high
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Decode
   assign ins_key   = KEY_WIDTH'(req_item.key);
   assign is_insert = (req_item.opcode == OP_INSERT);
   assign is_null   = (req_item.payload == '0);
   assign is_full   = (count_ff >= CW'(CAPACITY));
   assign is_empty  = (count_ff == '0);
   assign do_insert = accept && is_insert && !is_null && !is_full;
   assign do_remove = accept && (req_item.opcode == OP_REMOVE) && !is_empty;

   assign ctl.insert  = do_insert;
   assign ctl.remove  = do_remove;
   assign ctl.payload = req_item.payload;

   // Row of cells; ends tie off to the neighbor that does not exist
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                     l_ge;
      logic [KEY_WIDTH-1:0]     l_key, r_key;
      logic [PAYLOAD_WIDTH-1:0] l_payload, r_payload;

      if (i == 0) begin : g_head
         assign l_ge      = 1'b1;
         assign l_key     = '0;
         assign l_payload = '0;
      end else begin : g_body
         assign l_ge      = cell_ge[i-1];
         assign l_key     = cell_key[i-1];
         assign l_payload = cell_payload[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign r_key     = '0;
         assign r_payload = '0;
      end else begin : g_next
         assign r_key     = cell_key[i+1];
         assign r_payload = cell_payload[i+1];
      end

      smpq_cell #(
         .KEY_WIDTH (KEY_WIDTH)
      ) u_cell (
         .clock         (clock),
         .ctl           (ctl),
         .ins_key       (ins_key),
         .occupied      (CW'(i) < count_ff),
         .left_ge       (l_ge),
         .left_key      (l_key),
         .left_payload  (l_payload),
         .right_key     (r_key),
         .right_payload (r_payload),
         .ge            (cell_ge[i]),
         .key           (cell_key[i]),
         .payload       (cell_payload[i])
      );
   end

   // Entry count; insert and remove never come together
   always_comb begin
      count_in = count_ff;
      if (do_insert) begin
         count_in = count_ff + CW'(1);
      end else if (do_remove) begin
         count_in = count_ff - CW'(1);
      end
   end

   // Result beat: an insert echoes its own key; other commands report the front cell before it moves
   always_comb begin
      rsp_in.count = COUNT_PORT_WIDTH'(count_in);
      priority if (is_insert) begin
         rsp_in.front_key     = KEY_PORT_WIDTH'(ins_key);
         rsp_in.front_payload = '0;
         priority if (is_null) begin
            rsp_in.status = ST_NULL;
         end else if (is_full) begin
            rsp_in.status = ST_FULL;
         end else begin
            rsp_in.status        = ST_OK;
            rsp_in.front_payload = req_item.payload;
         end
      end else if (is_empty) begin
         rsp_in.status        = ST_EMPTY;
         rsp_in.front_key     = '0;
         rsp_in.front_payload = '0;
      end else begin
         rsp_in.status        = ST_OK;
         rsp_in.front_key     = KEY_PORT_WIDTH'(cell_key[0]);
         rsp_in.front_payload = cell_payload[0];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // Checks
   `SMPQ_ASSERT_NEXT(a_rsp_follows_cmd, clock, reset, accept, rsp_valid_ff)
   `SMPQ_ASSERT_NEXT(a_no_rsp_without_cmd, clock, reset, !accept, !rsp_valid_ff)
   `SMPQ_ASSERT_NOW(a_count_bounded, clock, reset, 1'b1, count_ff <= CW'(CAPACITY))
   `SMPQ_ASSERT_NEXT(a_insert_grows, clock, reset, do_insert, count_ff == $past(count_ff) + CW'(1))
   `SMPQ_ASSERT_NOW(a_front_sorted, clock, reset, count_ff >= CW'(2), cell_key[0] >= cell_key[1])

endmodule

[hw/rtl/smpq_cell.sv]
// One slot of the sorted row: holds a key and payload, shifts right on insert
// and left on remove. Depends on smpq_pkg.
module smpq_cell #(
   parameter int KEY_WIDTH = smpq_pkg::DEF_KEY_WIDTH
) (
   input  logic                               clock,
   input  smpq_pkg::cell_ctl_type             ctl,
   input  logic [KEY_WIDTH-1:0]               ins_key,
   input  logic                               occupied,
   input  logic                               left_ge,
   input  logic [KEY_WIDTH-1:0]               left_key,
   input  logic [smpq_pkg::PAYLOAD_WIDTH-1:0] left_payload,
   input  logic [KEY_WIDTH-1:0]               right_key,
   input  logic [smpq_pkg::PAYLOAD_WIDTH-1:0] right_payload,
   output logic                               ge,
   output logic [KEY_WIDTH-1:0]               key,
   output logic [smpq_pkg::PAYLOAD_WIDTH-1:0] payload
);
   import smpq_pkg::*;

   logic [KEY_WIDTH-1:0]     key_ff, key_in;
   logic [PAYLOAD_WIDTH-1:0] payload_ff, payload_in;

   // This entry stays ahead of the new key (ties keep arrival order)
   assign ge = occupied && (key_ff >= ins_key);

   // Next slot contents; insert and remove never come together
   always_comb begin
      key_in     = key_ff;
      payload_in = payload_ff;
      if (ctl.insert) begin
         if (!ge) begin
            if (left_ge) begin
               key_in     = ins_key;
               payload_in = ctl.payload;
            end else begin
               key_in     = left_key;
               payload_in = left_payload;
            end
         end
      end else if (ctl.remove) begin
         key_in     = right_key;
         payload_in = right_payload;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      payload_ff <= payload_in;
   end

   assign key     = key_ff;
   assign payload = payload_ff;

endmodule
